>>> rtl/core/rss_pkg.sv
`default_nettype none

package rss_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned DrawW = 31;
  localparam int unsigned StatW = 2;
  localparam int unsigned MembW = 7;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_SAMPLE = 2'd2;

  localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatW-1:0] STAT_MISS  = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd2;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ValW-1:0]   value;
    logic [DrawW-1:0]  draw;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/random_sample_set.sv
// channel  handshake                 payload
// in       in_valid_i / in_ready_o   op_i, value_i, random_draw_i
// out      out_valid_o / out_ready_i status_o, element_o, members_o
//
// insert and remove walk the occupied slots one per cycle through the single
// memory read port, and remove then adds the MOVE_RD and MOVE_WR states for the move
// get random takes its slot index from the bit-serial modulo unit
// a two-item queue behind the input lets items arrive while one executes
// reset clears the member count and all handshake state, store contents stay
// a stalled output holds the back end at its next result, input stops once
// the two-item queue is full
`default_nettype none

module random_sample_set #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rss_pkg::OpW-1:0]           op_i,
  input  logic signed [rss_pkg::ValW-1:0]   value_i,
  input  logic [rss_pkg::DrawW-1:0]         random_draw_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rss_pkg::StatW-1:0]         status_o,
  output logic signed [rss_pkg::ValW-1:0]   element_o,
  output logic [rss_pkg::MembW-1:0]         members_o
);

  logic          cmd_valid, cmd_ready;
  rss_pkg::cmd_t cmd;

  rss_front u_rss_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .random_draw_i (random_draw_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  rss_back #(
    .CAPACITY (CAPACITY)
  ) u_rss_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .members_o   (members_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/rss_front.sv
`default_nettype none

module rss_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rss_pkg::OpW-1:0]           op_i,
  input  logic signed [rss_pkg::ValW-1:0]   value_i,
  input  logic [rss_pkg::DrawW-1:0]         random_draw_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output rss_pkg::cmd_t                     cmd_o
);

  rss_pkg::cmd_t fifo_q [2];
  rss_pkg::cmd_t new_cmd;
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  always_comb begin
    new_cmd.value = value_i;
    new_cmd.draw  = random_draw_i;
    case (op_i)
      rss_pkg::OP_INSERT: new_cmd.kind = rss_pkg::CMD_INSERT;
      rss_pkg::OP_REMOVE: new_cmd.kind = rss_pkg::CMD_REMOVE;
      rss_pkg::OP_SAMPLE: new_cmd.kind = rss_pkg::CMD_SAMPLE;
      default:            new_cmd.kind = rss_pkg::CMD_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
  assign fill_d   = fill_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rss_div.sv
`default_nettype none

module rss_div #(
  parameter int unsigned DvsW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rss_pkg::DrawW-1:0]  dividend_i,
  input  logic [DvsW-1:0]            divisor_i,
  output logic                       done_o,
  output logic [DvsW-1:0]            rem_o
);

  localparam int unsigned StepW = $clog2(rss_pkg::DrawW + 1);

  logic [rss_pkg::DrawW-1:0] dvd_q;
  logic [DvsW-1:0]           dvs_q;
  logic [DvsW-1:0]           rem_q, rem_d;
  logic [StepW-1:0]          step_q;
  logic                      busy_q, done_q;
  logic [DvsW:0]             trial, diff;
  logic                      ge;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_q, dvd_q[rss_pkg::DrawW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];

  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[rss_pkg::DrawW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(rss_pkg::DrawW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rss_back.sv
`default_nettype none

module rss_back #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  rss_pkg::cmd_t                     cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rss_pkg::StatW-1:0]         status_o,
  output logic signed [rss_pkg::ValW-1:0]   element_o,
  output logic [rss_pkg::MembW-1:0]         members_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ValW = rss_pkg::ValW;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SCAN     = 8'b0000_0010,
    ST_MOVE_RD  = 8'b0000_0100,
    ST_MOVE_WR  = 8'b0000_1000,
    ST_DIV      = 8'b0001_0000,
    ST_GET_RD   = 8'b0010_0000,
    ST_GET_WAIT = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_e;

  state_e                     state_q, state_d;
  rss_pkg::cmd_t              cmd_q, cmd_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            scan_q, scan_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]            rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]            slot_q, slot_d;
  logic [rss_pkg::StatW-1:0]  res_stat_q, res_stat_d;
  logic [ValW-1:0]            res_elem_q, res_elem_d;
  logic                       out_valid_q, out_valid_d;
  logic [rss_pkg::StatW-1:0]  out_stat_q;
  logic [ValW-1:0]            out_elem_q;
  logic [rss_pkg::MembW-1:0]  out_memb_q;
  logic                       out_load;

  logic [ValW-1:0]            mem [CAPACITY];
  logic [ValW-1:0]            rd_q;
  logic [IdxW-1:0]            raddr, waddr;
  logic [ValW-1:0]            wdata;
  logic                       we;

  logic                       issue, hit;
  logic                       div_start, div_done;
  logic [CntW-1:0]            div_rem;

  rss_div #(
    .DvsW (CntW)
  ) u_rss_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.draw),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign issue       = (scan_q < count_q);
  assign hit         = rd_vld_q && (rd_q == cmd_q.value);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    scan_d     = scan_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = scan_q[IdxW-1:0];
    slot_d     = slot_q;
    res_stat_d = res_stat_q;
    res_elem_d = res_elem_q;
    out_load   = 1'b0;
    raddr      = scan_q[IdxW-1:0];
    waddr      = count_q[IdxW-1:0];
    wdata      = cmd_q.value;
    we         = 1'b0;
    div_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          res_stat_d = rss_pkg::STAT_DONE;
          res_elem_d = '0;
          case (cmd_i.kind)
            rss_pkg::CMD_INSERT, rss_pkg::CMD_REMOVE: begin
              scan_d  = '0;
              state_d = ST_SCAN;
            end
            rss_pkg::CMD_SAMPLE: begin
              if (count_q == '0) begin
                res_stat_d = rss_pkg::STAT_EMPTY;
                state_d    = ST_RESP;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      // reads go out one slot per cycle, each compare follows in the next cycle
      ST_SCAN: begin
        rd_vld_d = issue;
        scan_d   = scan_q + CntW'(issue);
        if (hit) begin
          slot_d = rd_idx_q;
          if (cmd_q.kind == rss_pkg::CMD_INSERT) begin
            res_stat_d = rss_pkg::STAT_MISS;
            state_d    = ST_RESP;
          end else begin
            state_d = ST_MOVE_RD;
          end
        end else if (!issue && !rd_vld_q) begin
          if (cmd_q.kind == rss_pkg::CMD_INSERT) begin
            if (count_q == CntW'(CAPACITY)) begin
              res_stat_d = rss_pkg::STAT_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
            end
          end else begin
            res_stat_d = rss_pkg::STAT_MISS;
          end
          state_d = ST_RESP;
        end
      end

      ST_MOVE_RD: begin
        raddr   = IdxW'(count_q - 1'b1);
        state_d = ST_MOVE_WR;
      end

      // last member fills the hole
      ST_MOVE_WR: begin
        we      = 1'b1;
        waddr   = slot_q;
        wdata   = rd_q;
        count_d = count_q - 1'b1;
        state_d = ST_RESP;
      end

      ST_DIV: begin
        if (div_done) begin
          state_d = ST_GET_RD;
        end
      end

      ST_GET_RD: begin
        raddr   = div_rem[IdxW-1:0];
        state_d = ST_GET_WAIT;
      end

      ST_GET_WAIT: begin
        res_elem_d = rd_q;
        state_d    = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_idx_q   <= rd_idx_d;
    slot_q     <= slot_d;
    res_stat_q <= res_stat_d;
    res_elem_q <= res_elem_d;
    if (out_load) begin
      out_stat_q <= res_stat_q;
      out_elem_q <= res_elem_q;
      out_memb_q <= rss_pkg::MembW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign element_o   = out_elem_q;
  assign members_o   = out_memb_q;

endmodule

`default_nettype wire

>>> rtl/core/rss_checker.sv
`default_nettype none

module rss_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [rss_pkg::StatW-1:0]         status_o,
  input logic signed [rss_pkg::ValW-1:0]   element_o,
  input logic [rss_pkg::MembW-1:0]         members_o
);

  localparam logic [rss_pkg::MembW-1:0] FullMembs = rss_pkg::MembW'(CAPACITY);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(element_o) && $stable(members_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rss_pkg::STAT_EMPTY |-> members_o == '0 && element_o == '0)
    else $error("empty report with members or element");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rss_pkg::STAT_FULL |-> members_o == FullMembs)
    else $error("full report below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_o != '0 |-> status_o == rss_pkg::STAT_DONE)
    else $error("element returned on failed operation");

endmodule

bind random_sample_set rss_checker #(.CAPACITY(CAPACITY)) u_rss_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int unsigned Capacity = 64;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ValW-1:0]  element;
    logic [MembW-1:0] members;
  } outcome_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [OpW-1:0]          op_i          = '0;
  logic signed [ValW-1:0]  value_i       = '0;
  logic [DrawW-1:0]        random_draw_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [StatW-1:0]        status_o;
  logic signed [ValW-1:0]  element_o;
  logic [MembW-1:0]        members_o;

  // predictor state: packed members and their count
  logic [ValW-1:0] set_slots [Capacity];
  int unsigned     member_total = 0;
  outcome_t        outcome_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;

  random_sample_set #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .random_draw_i(random_draw_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .element_o    (element_o),
    .members_o    (members_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic predict_outcome(input logic [OpW-1:0] op, input logic [ValW-1:0] val,
                                 input logic [DrawW-1:0] draw);
    outcome_t    res;
    int          hit;
    int unsigned idx;
    res.status  = STAT_DONE;
    res.element = '0;
    hit = -1;
    for (int i = 0; i < member_total; i++) begin
      if (hit < 0 && set_slots[i] == val) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_MISS;
        end else if (member_total >= Capacity) begin
          res.status = STAT_FULL;
        end else begin
          set_slots[member_total] = val;
          member_total++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          res.status = STAT_MISS;
        end else begin
          // last member fills the hole
          set_slots[hit] = set_slots[member_total-1];
          member_total--;
        end
      end
      OP_SAMPLE: begin
        if (member_total == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          idx = {1'b0, draw} % member_total;
          res.element = set_slots[idx];
        end
      end
      default: ;
    endcase
    res.members = MembW'(member_total);
    outcome_q.push_back(res);
  endtask

  task automatic send_command(input logic [OpW-1:0] op, input logic [ValW-1:0] val,
                              input logic [DrawW-1:0] draw);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      // junk payload while no item is offered
      in_valid_i    = 1'b0;
      op_i          = OpW'($urandom());
      value_i       = $urandom();
      random_draw_i = DrawW'($urandom());
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    op_i          = op;
    value_i       = val;
    random_draw_i = draw;
    do @(posedge clk_i); while (!in_ready_o);
    predict_outcome(op, val, draw);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(9))
      0: return ValW'($urandom_range(15));
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_member();
    return set_slots[$urandom_range(member_total-1)];
  endfunction

  function automatic logic [DrawW-1:0] pick_draw();
    case ($urandom_range(3))
      0: return DrawW'($urandom_range(127));
      1: return {DrawW{1'b1}} - DrawW'($urandom_range(3));
      default: return DrawW'($urandom());
    endcase
  endfunction

  task automatic test_edge_cases();
    send_command(OP_SAMPLE, 32'h0, 31'h0);          // empty set
    send_command(OP_REMOVE, 32'd5, 31'h0);          // nothing to remove
    send_command(CMD_NOP, 32'h0, 31'h0);
    send_command(OP_INSERT, 32'h8000_0000, 31'h0);
    send_command(OP_INSERT, 32'h7fff_ffff, 31'h0);
    send_command(OP_INSERT, 32'h0000_0000, 31'h0);
    send_command(OP_INSERT, 32'hffff_ffff, 31'h0);
    send_command(OP_INSERT, 32'h7fff_ffff, 31'h0);  // already present
    send_command(OP_SAMPLE, 32'h0, 31'h0);
    send_command(OP_SAMPLE, 32'hdead_beef, 31'h7fff_ffff);
    send_command(OP_SAMPLE, 32'h0, 31'd1);
    send_command(OP_SAMPLE, 32'h0, 31'd2);
    send_command(OP_REMOVE, 32'h7fff_ffff, 31'h0);  // middle slot
    send_command(OP_REMOVE, 32'hffff_ffff, 31'h0);  // now in the middle slot
    send_command(OP_REMOVE, 32'd1234, 31'h0);
    send_command(CMD_NOP, 32'hffff_ffff, 31'h7fff_ffff);
    send_command(OP_SAMPLE, 32'h0, 31'd5);
    send_command(OP_REMOVE, 32'h8000_0000, 31'h0);
    send_command(OP_REMOVE, 32'h0000_0000, 31'h0);
    send_command(OP_SAMPLE, 32'h0, 31'h7fff_ffff);
    send_command(OP_INSERT, 32'h5555_5555, 31'h0);
    send_command(OP_INSERT, 32'haaaa_aaaa, 31'h0);
    send_command(OP_SAMPLE, 32'h0, 31'd1);
    send_command(OP_REMOVE, 32'h5555_5555, 31'h0);  // first slot, last moves down
    send_command(OP_REMOVE, 32'haaaa_aaaa, 31'h0);
    stop_sending();
  endtask

  task automatic test_fill_and_drain();
    int unsigned r;
    while (member_total < Capacity) begin
      if ($urandom_range(99) < 85) send_command(OP_INSERT, pick_value(), pick_draw());
      else send_command(OP_SAMPLE, $urandom(), pick_draw());
    end
    // full store: present value, new value, sampling and churn at the top
    send_command(OP_INSERT, pick_member(), pick_draw());
    send_command(OP_INSERT, $urandom(), pick_draw());
    send_command(OP_SAMPLE, $urandom(), {DrawW{1'b1}});
    send_command(OP_SAMPLE, $urandom(), DrawW'(Capacity - 1));
    send_command(OP_REMOVE, pick_member(), pick_draw());
    send_command(OP_INSERT, $urandom(), pick_draw());
    send_command(OP_INSERT, $urandom(), pick_draw());
    while (member_total > 0) begin
      r = $urandom_range(99);
      if (r < 85) send_command(OP_REMOVE, pick_member(), pick_draw());
      else if (r < 95) send_command(OP_SAMPLE, $urandom(), pick_draw());
      else send_command(OP_REMOVE, $urandom(), pick_draw());
    end
    send_command(OP_SAMPLE, $urandom(), pick_draw());
    send_command(OP_REMOVE, pick_value(), pick_draw());
    stop_sending();
  endtask

  task automatic test_mixed_traffic(input int unsigned count);
    int unsigned r;
    int unsigned ins_w;
    int unsigned rem_w;
    logic [ValW-1:0] val;
    for (int unsigned n = 0; n < count; n++) begin
      // alternate between growing and shrinking the set
      ins_w = ((n / 50) % 2 == 0) ? 55 : 20;
      rem_w = 75 - ins_w;
      r = $urandom_range(99);
      if (r < ins_w) begin
        val = (member_total > 0 && $urandom_range(4) == 0) ? pick_member() : pick_value();
        send_command(OP_INSERT, val, pick_draw());
      end else if (r < ins_w + rem_w) begin
        val = (member_total > 0 && $urandom_range(3) != 0) ? pick_member() : pick_value();
        send_command(OP_REMOVE, val, pick_draw());
      end else if (r < 97) begin
        send_command(OP_SAMPLE, $urandom(), pick_draw());
      end else begin
        send_command(CMD_NOP, $urandom(), pick_draw());
      end
    end
    stop_sending();
  endtask

  always @(posedge clk_i) begin
    outcome_t seen;
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{status_o, element_o, members_o};
      if (outcome_q.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d element %h members %0d",
                              seen.status, seen.element, seen.members));
      end else begin
        want = outcome_q.pop_front();
        if (seen.status !== want.status || seen.element !== want.element ||
            seen.members !== want.members) begin
          log_failure($sformatf(
            "mismatch: status exp %0d got %0d, element exp %h got %h, members exp %0d got %0d",
            want.status, seen.status, want.element, seen.element,
            want.members, seen.members));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_edge_cases();
    test_fill_and_drain();
    test_mixed_traffic(150);

    send_idle_pct  = 88;
    recv_stall_pct = 0;
    test_fill_and_drain();
    test_mixed_traffic(150);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    test_fill_and_drain();
    test_mixed_traffic(150);

    send_idle_pct  = 15;
    recv_stall_pct = 15;
    test_mixed_traffic(150);
    test_fill_and_drain();

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", outcome_q.size()));
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
